>>> rtl/core/jacobi_heat_stencil_sweep_macros.svh
// Assertion macros shared by the stencil sweep RTL.
`ifndef JACOBI_HEAT_STENCIL_SWEEP_MACROS_SVH
`define JACOBI_HEAT_STENCIL_SWEEP_MACROS_SVH

// Same-cycle implication, checked on clk, off during rst.
`define JHS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off during rst.
`define JHS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/jhs_pkg.sv
// Package: types and constants of the Jacobi stencil sweep.
package jhs_pkg;

  localparam int MAX_ROW_LENGTH_DEF = 128;
  localparam int MIN_EXTENT         = 3;
  localparam int OUT_DEPTH          = 8;
  localparam int OUT_PTR_W          = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W          = OUT_PTR_W + 1;

  localparam logic [7:0]  ROW_LENGTH_RESET = 8'd100;
  localparam logic [15:0] ROW_TOTAL_RESET  = 16'd100;

  localparam logic CFG_ROW_LENGTH = 1'b0;
  localparam logic CFG_ROW_TOTAL  = 1'b1;

  typedef logic signed [31:0] sample_t;

  typedef struct packed {
    sample_t cell_value;
    logic    frame_end;
  } result_t;

  typedef struct packed {
    logic    lo_valid;
    result_t lo;
    logic    hi_valid;
    result_t hi;
  } push_t;

endpackage

>>> rtl/core/jhs_ram.sv
// Generic RAM: one write port, two registered read ports, read-first.
module jhs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> rtl/core/jhs_out_fifo.sv
// Result queue: up to two pushes and one pop per cycle.
module jhs_out_fifo (
  input  logic                       clk,
  input  logic                       rst,
  input  jhs_pkg::push_t             push,
  input  logic                       pop_ready,
  output logic                       head_valid,
  output jhs_pkg::result_t           head,
  output logic [jhs_pkg::OUT_CNT_W-1:0] count
);
  import jhs_pkg::*;

  result_t                mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wp;
  logic [OUT_PTR_W-1:0]   rp;
  logic [OUT_PTR_W-1:0]   wp_next;
  logic [OUT_PTR_W-1:0]   rp_next;
  logic [OUT_CNT_W-1:0]   count_next;
  logic                   pop;

  assign head_valid = (count != '0);
  assign head       = mem[rp];
  assign pop        = head_valid && pop_ready;

  always_comb begin
    wp_next    = wp + OUT_PTR_W'(push.lo_valid) + OUT_PTR_W'(push.hi_valid);
    rp_next    = rp + OUT_PTR_W'(pop);
    count_next = count + OUT_CNT_W'(push.lo_valid) + OUT_CNT_W'(push.hi_valid)
                 - OUT_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.lo_valid) begin
      mem[wp] <= push.lo;
    end
    if (push.hi_valid) begin
      mem[wp + OUT_PTR_W'(1)] <= push.hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp_next;
      rp    <= rp_next;
      count <= count_next;
    end
  end

endmodule

>>> rtl/core/jacobi_heat_stencil_sweep.sv
// Top level: one Jacobi five-point sweep over a raster-order grid stream.
//
// Usage:
//   sample_valid/sample_ready take one Q16.16 cell per transaction, raster order.
//   result_valid/result_ready give cell_value and frame_end per transaction.
//   cfg_write/cfg_index/cfg_data set row_length (0) and row_total (1); write
//   only while no transaction is in flight.
// Throughput and ordering:
//   One sample per cycle while sample_ready is high. Results run one grid row
//   behind the input: each sample from row 1 on releases the cell above it,
//   pushed into the result queue from stage C. Last-row samples release two
//   results, so the last row drains at one result per cycle while result_ready
//   is high. The rate rests on two line RAMs: two reads and one write each.
// Reset:
//   Position returns to row 0, column 0; both registers return to 100. Line
//   RAMs are not cleared; each entry is written before it is read.
// Stall:
//   An 8-entry result queue decouples the sides; sample_ready drops once the
//   queue could not hold the worst-case results of every sample in flight.
`include "jacobi_heat_stencil_sweep_macros.svh"

module jacobi_heat_stencil_sweep #(
  parameter int MAX_ROW_LENGTH = jhs_pkg::MAX_ROW_LENGTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [15:0]      cfg_data,
  input  logic             sample_valid,
  output logic             sample_ready,
  input  jhs_pkg::sample_t sample,
  output logic             result_valid,
  input  logic             result_ready,
  output jhs_pkg::sample_t cell_value,
  output logic             frame_end
);
  import jhs_pkg::*;

  localparam int AW = $clog2(MAX_ROW_LENGTH);
  localparam logic [15:0] MAX_LEN16 = 16'(MAX_ROW_LENGTH);
  localparam logic [15:0] MIN16     = 16'(MIN_EXTENT);

  // configuration
  logic [7:0]  row_length;
  logic [15:0] row_total;

  // position
  logic [AW-1:0] col;
  logic [15:0]   row;

  // stage A (accept) decode
  logic          accept;
  logic [15:0]   len_eff;
  logic [15:0]   tot_eff;
  logic          last_col;
  logic          last_row;
  logic [AW-1:0] col_next_addr;
  logic [AW-1:0] col_prev_addr;

  // stage B
  logic          b_valid;
  sample_t       b_sample;
  logic [AW-1:0] b_col;
  logic          b_emit;
  logic          b_pass;
  logic          b_self;
  logic          b_fend;
  logic          b_fwd;
  sample_t       up_prev;

  // stage C
  logic               c_valid;
  sample_t            c_sample;
  sample_t            c_mid;
  logic signed [32:0] c_sum_hi;
  logic signed [32:0] c_sum_lo;
  logic               c_emit;
  logic               c_pass;
  logic               c_self;
  logic               c_fend;
  logic signed [33:0] c_sum;
  sample_t            c_quarter;
  result_t            c_main;
  result_t            c_own;

  // memories and queue
  sample_t mid_rd_c;
  sample_t mid_rd_n;
  sample_t up_rd_c;
  sample_t up_rd_p;
  push_t   push;
  result_t head;
  logic [OUT_CNT_W-1:0] q_count;
  logic [OUT_CNT_W:0]   need;

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= ROW_LENGTH_RESET;
      row_total  <= ROW_TOTAL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ROW_LENGTH: row_length <= cfg_data[7:0];
        CFG_ROW_TOTAL:  row_total  <= cfg_data;
        default: ;
      endcase
    end
  end

  // admission: reserve two queue entries per sample in flight
  always_comb begin
    need = (OUT_CNT_W+1)'({b_valid, 1'b0}) + (OUT_CNT_W+1)'({c_valid, 1'b0})
           + (OUT_CNT_W+1)'(2);
    sample_ready = ({1'b0, q_count} + need) <= (OUT_CNT_W+1)'(OUT_DEPTH);
  end
  assign accept = sample_valid && sample_ready;

  always_comb begin
    len_eff = {8'd0, row_length};
    if (len_eff < MIN16) begin
      len_eff = MIN16;
    end else if (len_eff > MAX_LEN16) begin
      len_eff = MAX_LEN16;
    end
    tot_eff = (row_total < MIN16) ? MIN16 : row_total;
    last_col = 16'(col) >= (len_eff - 16'd1);
    last_row = row >= (tot_eff - 16'd1);
    col_next_addr = last_col ? col : col + AW'(1);
    col_prev_addr = (col == '0) ? col : col - AW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? 16'd0 : row + 16'd1;
      end else begin
        col <= col + AW'(1);
      end
    end
  end

  // middle line: read c and c+1, sample written at accept (read-first)
  jhs_ram #(.WIDTH(32), .DEPTH(MAX_ROW_LENGTH)) u_middle (
    .clk     (clk),
    .we      (accept),
    .waddr   (col),
    .wdata   (sample),
    .raddr_a (col),
    .raddr_b (col_next_addr),
    .rdata_a (mid_rd_c),
    .rdata_b (mid_rd_n)
  );

  // upper line: read c and c-1, old middle written back from stage B
  jhs_ram #(.WIDTH(32), .DEPTH(MAX_ROW_LENGTH)) u_upper (
    .clk     (clk),
    .we      (b_valid),
    .waddr   (b_col),
    .wdata   (mid_rd_c),
    .raddr_a (col),
    .raddr_b (col_prev_addr),
    .rdata_a (up_rd_c),
    .rdata_b (up_rd_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    b_sample <= sample;
    b_col    <= col;
    b_emit   <= (row != 16'd0);
    b_pass   <= (row == 16'd1) || (col == '0) || last_col;
    b_self   <= last_row;
    b_fend   <= last_col;
    // left neighbor still being written back by the sample ahead
    b_fwd    <= b_valid && (b_col == col_prev_addr) && (col != '0);
  end

  assign up_prev = b_fwd ? c_mid : up_rd_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    c_sample <= b_sample;
    c_mid    <= mid_rd_c;
    c_sum_hi <= 33'(up_rd_c) + 33'(up_prev);
    c_sum_lo <= 33'(mid_rd_n) + 33'(b_sample);
    c_emit   <= b_emit;
    c_pass   <= b_pass;
    c_self   <= b_self;
    c_fend   <= b_fend;
  end

  always_comb begin
    c_sum     = 34'(c_sum_hi) + 34'(c_sum_lo);
    c_quarter = c_sum[33:2];
    c_main.cell_value = c_pass ? c_mid : c_quarter;
    c_main.frame_end  = 1'b0;
    c_own.cell_value  = c_sample;
    c_own.frame_end   = c_fend;
    push.lo_valid = c_valid && (c_emit || c_self);
    push.lo       = c_emit ? c_main : c_own;
    push.hi_valid = c_valid && c_emit && c_self;
    push.hi       = c_own;
  end

  jhs_out_fifo u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop_ready  (result_ready),
    .head_valid (result_valid),
    .head       (head),
    .count      (q_count)
  );

  assign cell_value = head.cell_value;
  assign frame_end  = head.frame_end;

  `JHS_ASSERT_NOW(a_queue_room, c_valid,
    ({1'b0, q_count} + (OUT_CNT_W+1)'(2)) <= (OUT_CNT_W+1)'(OUT_DEPTH),
    "result queue could overflow")
  `JHS_ASSERT_NEXT(a_accept_enters_b, accept, b_valid,
    "accepted sample did not enter stage B")
  `JHS_ASSERT_NOW(a_fwd_source, b_valid && b_fwd, c_valid,
    "forwarded neighbor has no source in stage C")
  `JHS_ASSERT_NOW(a_hi_needs_lo, push.hi_valid, push.lo_valid,
    "second push without first")

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the Jacobi five-point stencil sweep over raster-order frames.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import jhs_pkg::*;

  localparam int      LINE_DEPTH  = MAX_ROW_LENGTH_DEF;
  localparam int      STALL_LIMIT = 1000;
  localparam int      RANDOM_ITEMS = 60;
  localparam sample_t SAMPLE_MAX  = 32'sh7FFF_FFFF;
  localparam sample_t SAMPLE_MIN  = 32'sh8000_0000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = CFG_ROW_LENGTH;
  logic [15:0] cfg_data = '0;
  logic        sample_valid = 1'b0;
  logic        sample_ready;
  sample_t     sample = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  sample_t     cell_value;
  logic        frame_end;

  // Predictor state
  logic [7:0]  row_len = ROW_LENGTH_RESET;
  logic [15:0] row_tot = ROW_TOTAL_RESET;
  sample_t     upper_row [LINE_DEPTH];
  sample_t     middle_row [LINE_DEPTH];
  int          line_col = 0;
  int          line_row = 0;

  result_t     expected_cells [$];
  result_t     want;
  int          mismatches = 0;
  int          items_sent = 0;
  int          stall_cycles = 0;
  bit          steady = 1'b0;

  jacobi_heat_stencil_sweep #(
    .MAX_ROW_LENGTH(LINE_DEPTH)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample      (sample),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .cell_value  (cell_value),
    .frame_end   (frame_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int eff_len();
    if (row_len < MIN_EXTENT) return MIN_EXTENT;
    if (row_len > LINE_DEPTH) return LINE_DEPTH;
    return int'(row_len);
  endfunction

  function automatic int eff_tot();
    if (row_tot < MIN_EXTENT) return MIN_EXTENT;
    return int'(row_tot);
  endfunction

  // floor of the four-neighbor mean, formed at 34 bits
  function automatic sample_t quarter_of(sample_t a, sample_t b, sample_t c, sample_t d);
    logic signed [33:0] total;
    logic signed [33:0] shifted;
    total = 34'(a) + 34'(b) + 34'(c) + 34'(d);
    shifted = total >>> 2;
    return shifted[31:0];
  endfunction

  function automatic void predict_cell(sample_t v);
    int      len;
    int      tot;
    int      c;
    bit      last_col;
    bit      last_row;
    sample_t above;
    len = eff_len();
    tot = eff_tot();
    c = line_col;
    if (c >= LINE_DEPTH) c = LINE_DEPTH - 1;
    last_col = c >= len - 1;
    last_row = line_row >= tot - 1;
    if (line_row >= 1) begin
      above = middle_row[c];
      if (line_row != 1 && c != 0 && !last_col) begin
        above = quarter_of(upper_row[c], upper_row[c-1], middle_row[c+1], v);
      end
      expected_cells.push_back('{cell_value: above, frame_end: 1'b0});
    end
    upper_row[c] = middle_row[c];
    middle_row[c] = v;
    if (last_row) expected_cells.push_back('{cell_value: v, frame_end: last_col});
    if (last_col) begin
      line_col = 0;
      line_row = last_row ? 0 : ((line_row + 1) & 16'hFFFF);
    end else begin
      line_col = c + 1;
    end
  endfunction

  function automatic sample_t draw_sample(bit harsh);
    if (harsh) begin
      case ($urandom_range(0, 5))
        0: return SAMPLE_MAX;
        1: return SAMPLE_MIN;
        2: return -1;
        3: return 0;
        4: return 1;
        default: return sample_t'($urandom);
      endcase
    end
    return sample_t'($urandom);
  endfunction

  // Returns at the rising edge of the accepted transaction with valid still high.
  task automatic send_sample(input sample_t v);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample <= v;
    do @(posedge clk); while (!sample_ready);
    predict_cell(v);
    items_sent++;
  endtask

  // Sender holds off until every expected result is out and the pipeline is empty.
  task automatic wait_drained();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (expected_cells.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Upper byte of the row_length write is junk; only the low byte counts.
  task automatic set_grid(input logic [7:0] len8, input logic [15:0] tot16);
    cfg_write <= 1'b1;
    cfg_index <= CFG_ROW_LENGTH;
    cfg_data <= {8'($urandom), len8};
    row_len = len8;
    @(negedge clk);
    cfg_index <= CFG_ROW_TOTAL;
    cfg_data <= tot16;
    row_tot = tot16;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic run_frame(input bit harsh);
    do send_sample(draw_sample(harsh)); while (line_col != 0 || line_row != 0);
  endtask

  task automatic test_extremes();
    sample_t checker_grid [9] = '{SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX,
                                  SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN,
                                  SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX};
    sample_t mixed [12] = '{SAMPLE_MIN, SAMPLE_MAX, -1, 0,
                            1, SAMPLE_MIN, SAMPLE_MIN, -2,
                            SAMPLE_MAX, SAMPLE_MIN, -1, 32'sh0001_0000};
    wait_drained();
    set_grid(8'd2, 16'd1);  // both clamp to 3
    foreach (checker_grid[i]) send_sample(checker_grid[i]);
    wait_drained();
    set_grid(8'd4, 16'd0);
    foreach (mixed[i]) send_sample(mixed[i]);
  endtask

  // Shrink the extents mid-frame with the position past the new last column, once also past the new last row.
  task automatic test_midframe_change();
    wait_drained();
    set_grid(8'd10, 16'hFFFF);
    repeat (56) send_sample(draw_sample(1'b0));
    wait_drained();
    set_grid(8'd4, 16'd3);
    run_frame(1'b0);
    wait_drained();
    set_grid(8'd6, 16'd5);
    repeat (9) send_sample(draw_sample(1'b1));
    wait_drained();
    set_grid(8'd3, 16'd5);
    run_frame(1'b1);
  endtask

  // Row length above the line depth clamps to the full line, sent back to back.
  task automatic test_widest();
    wait_drained();
    set_grid(8'd200, 16'd3);
    steady = 1'b1;
    run_frame(1'b0);
    steady = 1'b0;
  endtask

  task automatic test_random_frames();
    int          goal;
    int          frame_size;
    int          cut;
    bit          harsh;
    logic [7:0]  len8;
    logic [15:0] tot16;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      wait_drained();
      steady = ($urandom_range(0, 3) == 0);
      harsh = ($urandom_range(0, 4) == 0);
      len8 = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 2)) : 8'($urandom_range(3, 8));
      tot16 = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 2)) :
                                            16'($urandom_range(3, 6));
      set_grid(len8, tot16);
      if ($urandom_range(0, 5) == 0) begin
        frame_size = eff_len() * eff_tot();
        cut = $urandom_range(1, frame_size - 1);
        repeat (cut) send_sample(draw_sample(harsh));
        wait_drained();
        // row length may only shrink here, so no line entry is read unwritten
        set_grid(8'($urandom_range(0, eff_len())), 16'($urandom_range(0, 8)));
      end
      run_frame(harsh);
    end
    steady = 1'b0;
  endtask

  initial begin : result_sink
    int hold;
    forever begin
      hold = steady ? 0 : $urandom_range(0, 7);
      @(negedge clk);
      if (hold > 0) begin
        result_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!(result_valid && !rst));
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_cells.size() == 0) begin
        $error("unexpected result transaction: cell_value %h frame_end %b", cell_value,
               frame_end);
        mismatches++;
      end else begin
        want = expected_cells.pop_front();
        if (cell_value !== want.cell_value) begin
          $error("cell_value: expected %h, actual %h", want.cell_value, cell_value);
          mismatches++;
        end
        if (frame_end !== want.frame_end) begin
          $error("frame_end: expected %b, actual %b", want.frame_end, frame_end);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((sample_valid && sample_ready) || (result_valid && result_ready) || cfg_write) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_extremes();
    test_midframe_change();
    test_widest();
    test_random_frames();
    wait_drained();
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
